@@ hdl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the bank-switching mapper with scanline IRQ.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // Bus access kinds
    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_PPU_READ  = 2'd2,
        OP_NT_REMAP  = 2'd3
    } bsm_op_t;

    // Memory that serves an access
    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_WRAM = 3'd1,
        TGT_PRG  = 3'd2,
        TGT_CHR  = 3'd3,
        TGT_NT   = 3'd4
    } bsm_target_t;

    // Register groups decoded from CPU address bits 14:13 above 0x8000
    typedef enum logic [1:0] {
        RG_BANK   = 2'd0,
        RG_MIRROR = 2'd1,
        RG_IRQ    = 2'd2,
        RG_ENABLE = 2'd3
    } bsm_reg_group_t;

    // Configuration register indexes
    localparam logic CFG_PRG_UNITS = 1'b0;
    localparam logic CFG_FIXED_NT  = 1'b1;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CYCLE_W  = 32;
    localparam int unsigned MAP_W    = 21;
    localparam int unsigned NUM_BANK = 8;

    // Spacing that a pattern fetch must exceed to pass the A12 filter, in video clocks
    localparam logic [CYCLE_W-1:0] A12_FILTER_CYCLES = 32'd3;

    localparam logic [ADDR_W-1:0] LAST_ADDR_RESET = 16'hFFFF;
    localparam logic [7:0]        PRG_UNITS_RESET = 8'd2;

    // One bus access
    typedef struct packed {
        bsm_op_t              op;
        logic [ADDR_W-1:0]    address;
        logic [DATA_W-1:0]    write_data;
        logic [CYCLE_W-1:0]   ppu_cycle;
    } bsm_item_t;

    // Mapping state seen by the translator
    typedef struct packed {
        logic [DATA_W-1:0]                 bank_select;
        logic [NUM_BANK-1:0][DATA_W-1:0]   bank_regs;
        logic                              mirror_horizontal;
    } bsm_map_state_t;

endpackage

@@ hdl/bsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsm_ctrl
// Mapper register file, A12 edge filter and scanline IRQ counter.
// ----------------------------------------------------------------------------
module bsm_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     commit,
    input  bsm_pkg::bsm_item_t       item,
    output bsm_pkg::bsm_map_state_t  map_state,
    output logic                     irq_pulse
);
    import bsm_pkg::*;

    logic [DATA_W-1:0]               bank_select_reg, bank_select_next;
    logic [NUM_BANK-1:0][DATA_W-1:0] bank_regs_reg, bank_regs_next;
    logic                            mirror_reg, mirror_next;
    logic [7:0]                      latch_reg, latch_next;
    logic                            reload_reg, reload_next;
    logic [7:0]                      count_reg, count_next;
    logic                            enable_reg, enable_next;
    logic [CYCLE_W-1:0]              last_cycle_reg, last_cycle_next;
    logic [ADDR_W-1:0]               last_addr_reg, last_addr_next;

    logic [CYCLE_W-1:0]              cycle_gap;
    logic                            is_even;

    assign cycle_gap = item.ppu_cycle - last_cycle_reg;
    assign is_even   = ~item.address[0];

    assign map_state.bank_select       = bank_select_reg;
    assign map_state.bank_regs         = bank_regs_reg;
    assign map_state.mirror_horizontal = mirror_reg;

    // Decode register writes and clock the counter on a filtered A12 rise
    always_comb begin
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        mirror_next      = mirror_reg;
        latch_next       = latch_reg;
        reload_next      = reload_reg;
        count_next       = count_reg;
        enable_next      = enable_reg;
        last_cycle_next  = last_cycle_reg;
        last_addr_next   = last_addr_reg;
        irq_pulse        = 1'b0;
        if (commit) begin
            unique case (item.op)
                OP_CPU_WRITE: begin
                    if (item.address[15]) begin
                        unique case (bsm_reg_group_t'(item.address[14:13]))
                            RG_BANK: begin
                                if (is_even) begin
                                    bank_select_next = item.write_data;
                                end else begin
                                    bank_regs_next[bank_select_reg[2:0]] = item.write_data;
                                end
                            end
                            RG_MIRROR: begin
                                // odd addresses are RAM protect: ignore
                                if (is_even) begin
                                    mirror_next = item.write_data[0];
                                end
                            end
                            RG_IRQ: begin
                                if (is_even) begin
                                    latch_next = item.write_data;
                                end else begin
                                    reload_next = 1'b1;
                                end
                            end
                            RG_ENABLE: begin
                                enable_next = item.address[0];
                            end
                            default: begin
                                enable_next = enable_reg;
                            end
                        endcase
                    end
                end
                OP_PPU_READ: begin
                    if (item.address[15:13] == 3'b000 && cycle_gap > A12_FILTER_CYCLES) begin
                        last_cycle_next = item.ppu_cycle;
                        last_addr_next  = item.address;
                        if (!last_addr_reg[12] && item.address[12]) begin
                            if (count_reg == 8'd0 || reload_reg) begin
                                count_next  = latch_reg;
                                reload_next = 1'b0;
                            end else begin
                                count_next = count_reg - 8'd1;
                            end
                            irq_pulse = (count_next == 8'd0) && enable_reg;
                        end
                    end
                end
                default: begin
                    irq_pulse = 1'b0;
                end
            endcase
        end
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg <= '0;
            bank_regs_reg   <= '0;
            mirror_reg      <= 1'b0;
            latch_reg       <= '0;
            reload_reg      <= 1'b0;
            count_reg       <= '0;
            enable_reg      <= 1'b0;
            last_cycle_reg  <= '0;
            last_addr_reg   <= LAST_ADDR_RESET;
        end else begin
            bank_select_reg <= bank_select_next;
            bank_regs_reg   <= bank_regs_next;
            mirror_reg      <= mirror_next;
            latch_reg       <= latch_next;
            reload_reg      <= reload_next;
            count_reg       <= count_next;
            enable_reg      <= enable_next;
            last_cycle_reg  <= last_cycle_next;
            last_addr_reg   <= last_addr_next;
        end
    end

endmodule

@@ hdl/bsm_xlate.sv @@
// ----------------------------------------------------------------------------
// bsm_xlate
// Address translation: target memory and address for one bus access.
// ----------------------------------------------------------------------------
module bsm_xlate (
    input  bsm_pkg::bsm_item_t       item,
    input  bsm_pkg::bsm_map_state_t  map_state,
    input  logic [7:0]               prg_rom_units_16k,
    input  logic                     fixed_nametable,
    output bsm_pkg::bsm_target_t     target,
    output logic [20:0]              mapped_address
);
    import bsm_pkg::*;

    logic [7:0]  second_last;
    logic [7:0]  last_bank;
    logic [7:0]  r6;
    logic [7:0]  r7;
    logic [7:0]  prg_bank;
    logic [2:0]  chr_slot;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_bank;
    logic [15:0] nt_addr;
    logic        is_wram;

    // Fixed banks follow from ROM size, modulo 256
    assign second_last = {prg_rom_units_16k[6:0], 1'b0} - 8'd2;
    assign last_bank   = {second_last[7:1], 1'b1};
    assign r6          = {2'b00, map_state.bank_regs[6][5:0]};
    assign r7          = {2'b00, map_state.bank_regs[7][5:0]};
    assign is_wram     = (item.address[15:13] == 3'b011);

    // Select the 8 KB program bank
    always_comb begin
        case (item.address[14:13])
            2'd0:    prg_bank = map_state.bank_select[6] ? second_last : r6;
            2'd1:    prg_bank = r7;
            2'd2:    prg_bank = map_state.bank_select[6] ? r6 : second_last;
            default: prg_bank = last_bank;
        endcase
    end

    // Pick the pattern bank register; layout flips on bank_select bit 7
    assign chr_slot = item.address[12:10];
    always_comb begin
        if (map_state.bank_select[7]) begin
            chr_idx = chr_slot[2] ? {2'b00, chr_slot[1]}
                                  : (3'd2 + {1'b0, chr_slot[1:0]});
        end else begin
            chr_idx = chr_slot[2] ? (3'd2 + {1'b0, chr_slot[1:0]})
                                  : {2'b00, chr_slot[1]};
        end
    end
    assign chr_bank = map_state.bank_regs[chr_idx];

    // Fold nametable space: horizontal mirroring moves A11 into A10
    always_comb begin
        nt_addr = item.address;
        if (map_state.mirror_horizontal) begin
            nt_addr[10] = item.address[11];
        end
        nt_addr[11] = 1'b0;
    end

    always_comb begin
        target         = TGT_NONE;
        mapped_address = '0;
        unique case (item.op)
            OP_CPU_READ, OP_CPU_WRITE: begin
                if (is_wram) begin
                    target         = TGT_WRAM;
                    mapped_address = {8'd0, item.address[12:0]};
                end else if (item.address[15] && item.op == OP_CPU_READ) begin
                    target         = TGT_PRG;
                    mapped_address = {prg_bank, item.address[12:0]};
                end
            end
            OP_PPU_READ: begin
                if (item.address[15:13] == 3'b000) begin
                    target = TGT_CHR;
                    if (chr_idx[2:1] == 2'b00) begin
                        mapped_address = {3'd0, chr_bank[7:1], item.address[10:0]};
                    end else begin
                        mapped_address = {3'd0, chr_bank, item.address[9:0]};
                    end
                end
            end
            OP_NT_REMAP: begin
                if (item.address[15:12] == 4'h2 && !fixed_nametable) begin
                    target         = TGT_NT;
                    mapped_address = {5'd0, nt_addr};
                end
            end
            default: begin
                target = TGT_NONE;
            end
        endcase
    end

endmodule

@@ hdl/bank_switch_mapper_scanline_irq_core.sv @@
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_core
// Cartridge bank-switching mapper with scanline IRQ counter.
//
// Each input word is one bus access (CPU read, CPU write, video pattern
// fetch or nametable remap); each produces exactly one output word holding
// the memory that serves it, the translated address and an IRQ pulse flag.
// An access is registered on entry, then translated and applied to the
// mapper registers as it moves into the output register; one word is taken
// every cycle, limited only by the output side's tready. The mapper state
// is updated as each word moves to the output register, so back-to-back
// accesses see all earlier writes and counter clocks. Configuration writes
// are applied at once and must only be issued while no word is in flight.
// The ROMs and work RAM are external.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_core (
    input  logic        aclk,
    input  logic        aresetn,
    // config: 0 prg_rom_units_16k, 1 fixed_nametable
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // address[15:0], write_data[23:16], ppu_cycle[55:24]
    input  logic [1:0]  s_tuser,  // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // mapped_address[20:0], irq_pulse[21], zero[23:22]
    output logic [2:0]  m_tuser   // target[2:0]
);
    import bsm_pkg::*;

    logic                 in_valid_reg;
    bsm_item_t            in_item_reg;
    logic                 out_valid_reg;
    bsm_target_t          out_target_reg;
    logic [MAP_W-1:0]     out_addr_reg;
    logic                 out_pulse_reg;
    logic [7:0]           prg_units_reg;
    logic                 fixed_nt_reg;

    logic                 advance;
    bsm_map_state_t       map_state;
    logic                 irq_pulse;
    bsm_target_t          target;
    logic [MAP_W-1:0]     mapped_address;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bsm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit    (advance),
        .item      (in_item_reg),
        .map_state (map_state),
        .irq_pulse (irq_pulse)
    );

    bsm_xlate u_xlate (
        .item              (in_item_reg),
        .map_state         (map_state),
        .prg_rom_units_16k (prg_units_reg),
        .fixed_nametable   (fixed_nt_reg),
        .target            (target),
        .mapped_address    (mapped_address)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_units_reg <= PRG_UNITS_RESET;
            fixed_nt_reg  <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_PRG_UNITS) begin
                prg_units_reg <= cfg_wdata;
            end else begin
                fixed_nt_reg <= cfg_wdata[0];
            end
        end
    end

    // Input register: take a word whenever the slot frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op         <= bsm_op_t'(s_tuser);
            in_item_reg.address    <= s_tdata[15:0];
            in_item_reg.write_data <= s_tdata[23:16];
            in_item_reg.ppu_cycle  <= s_tdata[55:24];
        end
    end

    // Output register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_target_reg <= target;
            out_addr_reg   <= mapped_address;
            out_pulse_reg  <= irq_pulse;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pulse_reg, out_addr_reg};
    assign m_tuser  = out_target_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bank-switching mapper with scanline IRQ.
// Bus accesses go in through the slave stream, and a mapper model in the
// bench predicts the target, translated address and IRQ flag of each
// accepted word. Output words are compared in order against that model.
// Phases cover directed corner accesses, then random traffic under several
// idle and stall patterns and ROM size / nametable settings, plus a long
// output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module testbench;
    import bsm_pkg::*;

    localparam int   CYCLE_LIMIT   = 200000;

    typedef struct packed {
        bsm_target_t  target;
        logic [20:0]  mapped;
        logic         irq;
    } bus_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;   // address[15:0], write_data[23:16], ppu_cycle[55:24]
    logic [1:0]  s_tuser   = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // mapped_address[20:0], irq_pulse[21], zero[23:22]
    logic [2:0]  m_tuser;          // target[2:0]

    // Mapper model state
    logic [7:0]  prg_units      = PRG_UNITS_RESET;
    logic        fixed_nt       = 1'b0;
    logic [7:0]  bank_sel       = '0;
    logic [7:0]  bank_reg [8]   = '{default: 8'd0};
    logic        mirror_h       = 1'b0;
    logic [7:0]  irq_latch      = '0;
    logic        reload_pending = 1'b0;
    logic [7:0]  irq_cnt        = '0;
    logic        irq_en         = 1'b0;
    logic [31:0] last_cycle     = '0;
    logic [15:0] last_addr      = LAST_ADDR_RESET;

    bus_result_t pending_results [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          src_idle_pct   = 0;
    int          rcv_stall_pct  = 0;
    int          hold_len       = 0;
    logic [31:0] video_clock    = '0;
    logic        a12_phase      = 1'b0;

    bank_switch_mapper_scanline_irq_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Clock the scanline counter once; return the IRQ flag
    function automatic logic clock_scanline();
        if (irq_cnt == 8'd0 || reload_pending) begin
            irq_cnt = irq_latch;
            reload_pending = 1'b0;
        end else begin
            irq_cnt = irq_cnt - 8'd1;
        end
        return (irq_cnt == 8'd0) && irq_en;
    endfunction

    // Apply a CPU write in register space
    function automatic void write_mapper_reg(logic [15:0] a, logic [7:0] d);
        case (bsm_reg_group_t'(a[14:13]))
            RG_BANK: begin
                if (!a[0])
                    bank_sel = d;
                else
                    bank_reg[bank_sel[2:0]] = d;
            end
            RG_MIRROR: begin
                // odd addresses are RAM protect, ignored
                if (!a[0])
                    mirror_h = d[0];
            end
            RG_IRQ: begin
                if (!a[0])
                    irq_latch = d;
                else
                    reload_pending = 1'b1;
            end
            default: irq_en = a[0];
        endcase
    endfunction

    // Predict the result of one access and advance the mapper state
    function automatic bus_result_t translate_access(bsm_item_t it);
        bus_result_t r;
        logic [7:0]  bank;
        logic [7:0]  fixed_base;
        logic [2:0]  slot;
        logic [2:0]  idx;
        logic [15:0] nt;
        logic        was_low;
        r.target = TGT_NONE;
        r.mapped = '0;
        r.irq    = 1'b0;
        fixed_base = {prg_units[6:0], 1'b0};
        case (it.op)
            OP_CPU_READ, OP_CPU_WRITE: begin
                if (it.address >= 16'h6000 && it.address < 16'h8000) begin
                    r.target = TGT_WRAM;
                    r.mapped = {8'd0, it.address[12:0]};
                end else if (it.address >= 16'h8000 && it.op == OP_CPU_WRITE) begin
                    write_mapper_reg(it.address, it.write_data);
                end else if (it.address >= 16'h8000) begin
                    case (it.address[14:13])
                        2'd0: bank = bank_sel[6] ? fixed_base - 8'd2 : bank_reg[6] & 8'h3F;
                        2'd1: bank = bank_reg[7] & 8'h3F;
                        2'd2: bank = bank_sel[6] ? bank_reg[6] & 8'h3F : fixed_base - 8'd2;
                        default: bank = fixed_base - 8'd1;
                    endcase
                    r.target = TGT_PRG;
                    r.mapped = {bank, it.address[12:0]};
                end
            end
            OP_PPU_READ: begin
                if (it.address < 16'h2000) begin
                    // A12 edge filter: only widely spaced fetches count
                    if (it.ppu_cycle - last_cycle > A12_FILTER_CYCLES) begin
                        was_low = !last_addr[12];
                        last_cycle = it.ppu_cycle;
                        last_addr = it.address;
                        if (was_low && it.address[12])
                            r.irq = clock_scanline();
                    end
                    // inverted layout swaps the 2 KB and 1 KB halves
                    slot = it.address[12:10] ^ {bank_sel[7], 2'b00};
                    idx = slot[2] ? slot - 3'd2 : {2'b00, slot[1]};
                    bank = bank_reg[idx];
                    r.target = TGT_CHR;
                    if (idx < 3'd2)
                        r.mapped = {3'd0, bank[7:1], it.address[10:0]};
                    else
                        r.mapped = {3'd0, bank, it.address[9:0]};
                end
            end
            default: begin
                if (it.address >= 16'h2000 && it.address < 16'h3000 && !fixed_nt) begin
                    nt = it.address;
                    if (mirror_h)
                        nt[10] = it.address[11];
                    nt[11] = 1'b0;
                    r.target = TGT_NT;
                    r.mapped = {5'd0, nt};
                end
            end
        endcase
        return r;
    endfunction

    // Predict on every accepted input word
    always @(posedge aclk) begin : track_inputs
        bsm_item_t it;
        if (aresetn && s_tvalid && s_tready) begin
            it.op         = bsm_op_t'(s_tuser);
            it.address    = s_tdata[15:0];
            it.write_data = s_tdata[23:16];
            it.ppu_cycle  = s_tdata[55:24];
            pending_results.push_back(translate_access(it));
        end
    end

    // Compare every output word with the oldest prediction
    always @(posedge aclk) begin : check_results
        bus_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: output word with nothing expected: target=%0d addr=%h irq=%b",
                         $time, m_tuser, m_tdata[20:0], m_tdata[21]);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.target || m_tdata[20:0] != want.mapped
                        || m_tdata[21] != want.irq) begin
                    $display("%0t: mismatch: expected target=%0d addr=%h irq=%b, ",
                             $time, want.target, want.mapped, want.irq,
                             "got target=%0d addr=%h irq=%b",
                             m_tuser, m_tdata[20:0], m_tdata[21]);
                    mismatch_count++;
                end
            end
        end
    end

    // Drive output ready: long hold-off when requested, else random stalls
    always @(negedge aclk) begin
        if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    function automatic bsm_item_t make_access(bsm_op_t op, logic [15:0] a,
                                              logic [7:0] d, logic [31:0] cyc);
        bsm_item_t it;
        it.op = op;
        it.address = a;
        it.write_data = d;
        it.ppu_cycle = cyc;
        return it;
    endfunction

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(input bsm_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.ppu_cycle, it.write_data, it.address};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Hold until every predicted word has come out and the pipe is empty
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == CFG_PRG_UNITS)
            prg_units = value;
        else
            fixed_nt = value[0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic: bank and IRQ setup, alternating A12 fetches
    task automatic next_access(output bsm_item_t it);
        int pick;
        pick = $urandom_range(99);
        it.address    = 16'($urandom);
        it.write_data = 8'($urandom);
        it.ppu_cycle  = video_clock;
        if (pick < 5) begin
            // noise: any op, any cycle stamp
            it.op = bsm_op_t'($urandom_range(3));
            it.ppu_cycle = $urandom;
        end else if (pick < 22) begin
            it.op = OP_CPU_READ;
            if ($urandom_range(3) != 0)
                it.address = 16'h6000 + 16'($urandom_range(0, 16'h9FFF));
        end else if (pick < 45) begin
            it.op = OP_CPU_WRITE;
            if ($urandom_range(4) != 0) begin
                it.address = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
                // keep the latch small so the counter reaches zero often
                if (it.address[14:13] == RG_IRQ && !it.address[0]
                        && $urandom_range(3) != 0)
                    it.write_data = 8'($urandom_range(0, 6));
                if (it.address[14:13] == RG_ENABLE && $urandom_range(3) != 0)
                    it.address[0] = 1'b1;
            end
        end else if (pick < 85) begin
            it.op = OP_PPU_READ;
            video_clock = video_clock + $urandom_range(1, 8);
            it.ppu_cycle = video_clock;
            if ($urandom_range(9) < 7)
                a12_phase = !a12_phase;
            if ($urandom_range(19) != 0)
                it.address = {3'b000, a12_phase, 12'($urandom)};
        end else begin
            it.op = OP_NT_REMAP;
            if ($urandom_range(4) != 0)
                it.address = 16'h2000 + 16'($urandom_range(0, 16'h0FFF));
        end
    endtask

    task automatic run_random_phase(input int n, input int src_pct, input int rcv_pct,
                                    input logic [7:0] units, input logic fixed);
        bsm_item_t it;
        wait_idle();
        write_cfg(CFG_PRG_UNITS, units);
        write_cfg(CFG_FIXED_NT, {7'd0, fixed});
        src_idle_pct = src_pct;
        rcv_stall_pct = rcv_pct;
        repeat (n) begin
            next_access(it);
            send_word(it);
        end
        end_burst();
    endtask

    // Corner accesses: region edges, register decode, filter and IRQ pulse
    task automatic test_directed();
        src_idle_pct = 0;
        rcv_stall_pct = 0;
        send_word(make_access(OP_CPU_READ,  16'h0000, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_READ,  16'h5FFF, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_READ,  16'h6000, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_READ,  16'h8000, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_READ,  16'hFFFF, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'h7FFF, 8'hFF, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'h1234, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'h8000, 8'hC7, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'h8001, 8'hFF, 32'd0));
        send_word(make_access(OP_CPU_READ,  16'hA000, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_READ,  16'h8000, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'hA000, 8'h01, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'hA001, 8'h00, 32'd0));
        send_word(make_access(OP_NT_REMAP,  16'h2C00, 8'h00, 32'd0));
        send_word(make_access(OP_NT_REMAP,  16'h3000, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'hC000, 8'h01, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'hC001, 8'h00, 32'd0));
        send_word(make_access(OP_CPU_WRITE, 16'hE001, 8'h00, 32'd0));
        // fetches across the cycle counter wrap; second one is filtered out
        send_word(make_access(OP_PPU_READ,  16'h0000, 8'h00, 32'hFFFF_FFF6));
        send_word(make_access(OP_PPU_READ,  16'h1000, 8'h00, 32'hFFFF_FFF8));
        send_word(make_access(OP_PPU_READ,  16'h1FFF, 8'h00, 32'hFFFF_FFFE));
        send_word(make_access(OP_PPU_READ,  16'h0FFF, 8'h00, 32'h0000_0004));
        send_word(make_access(OP_PPU_READ,  16'h1000, 8'h00, 32'h0000_000A));
        send_word(make_access(OP_PPU_READ,  16'h2000, 8'h00, 32'h0000_0014));
        send_word(make_access(OP_CPU_WRITE, 16'hE000, 8'h00, 32'd0));
        end_burst();
        video_clock = $urandom;
    endtask

    task automatic test_no_idle();
        run_random_phase(320, 0, 0, 8'd1, 1'b0);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(300, 72, 0, 8'd255, 1'b1);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(300, 0, 72, 8'd129, 1'b0);
    endtask

    task automatic test_both_idle();
        run_random_phase(300, 7, 7, 8'd128, 1'b1);
    endtask

    // Hold the output off while words keep coming, then pause until drained
    task automatic test_backpressure();
        bsm_item_t it;
        wait_idle();
        write_cfg(CFG_PRG_UNITS, 8'd64);
        write_cfg(CFG_FIXED_NT, 8'd0);
        src_idle_pct = 0;
        rcv_stall_pct = 10;
        hold_len = 150;
        repeat (60) begin
            next_access(it);
            send_word(it);
        end
        end_burst();
        wait_idle();
        repeat (40) begin
            next_access(it);
            send_word(it);
        end
        end_burst();
    endtask

    task automatic test_random_config();
        run_random_phase(230, 20, 20, 8'($urandom_range(1, 255)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_backpressure();
        test_random_config();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ bank_switch_mapper_scanline_irq_core.f @@
hdl/bsm_pkg.sv
hdl/bsm_ctrl.sv
hdl/bsm_xlate.sv
hdl/bank_switch_mapper_scanline_irq_core.sv
test/testbench.sv
